[rtl/jsu_pkg.sv]
// Shared types, codes and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Decoder modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_HEX    = 3'd2;
    localparam logic [2:0] MODE_OUT    = 3'd3;

    // Result status codes
    localparam logic [3:0] ST_BUSY      = 4'd0;
    localparam logic [3:0] ST_DONE      = 4'd1;
    localparam logic [3:0] ST_CTRL      = 4'd2;
    localparam logic [3:0] ST_BAD_ESC   = 4'd3;
    localparam logic [3:0] ST_BAD_HEX   = 4'd4;
    localparam logic [3:0] ST_UNTERM    = 4'd5;
    localparam logic [3:0] ST_UNFIN_ESC = 4'd6;
    localparam logic [3:0] ST_SHORT_U   = 4'd7;
    localparam logic [3:0] ST_NOT_IN    = 4'd8;

    // Byte values the decoder looks for
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_U         = 8'h75;

    // Result queue sizing
    localparam int unsigned RESULT_DEPTH = 8;
    localparam int unsigned PTR_W        = $clog2(RESULT_DEPTH);
    localparam int unsigned CNT_W        = $clog2(RESULT_DEPTH + 1);
    localparam int unsigned MAX_BURST    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] status;
        logic       last_of_run;
    } jsu_result_t;

    // Results caused by one accepted request, slot 0 first
    typedef struct packed {
        logic [1:0]                       cnt;
        jsu_result_t [MAX_BURST-1:0]      res;
    } jsu_burst_t;

    // Hex digit value; bit 4 set when the byte is a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    // Simple escape map; bit 8 set when the escape letter is known
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] v;
        unique case (c)
            8'h22:   v = {1'b1, 8'h22};
            8'h5c:   v = {1'b1, 8'h5c};
            8'h2f:   v = {1'b1, 8'h2f};
            8'h62:   v = {1'b1, 8'h08};
            8'h66:   v = {1'b1, 8'h0c};
            8'h6e:   v = {1'b1, 8'h0a};
            8'h72:   v = {1'b1, 8'h0d};
            8'h74:   v = {1'b1, 8'h09};
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/jsu_decode.sv]
// Escape decoder: holds the string state and turns one request into up to three results.
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       input_end,
    input  wire logic       restart,
    output jsu_burst_t      burst
);

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;

    logic [2:0]  mode_eff;
    logic [1:0]  hex_cnt_eff;
    logic [15:0] cp_eff;
    logic [15:0] cp_new;
    logic [4:0]  hex_d;
    logic [8:0]  esc_d;

    always_comb
    begin
        mode_eff    = restart ? MODE_NORMAL : mode_reg;
        hex_cnt_eff = restart ? 2'd0 : hex_cnt_reg;
        cp_eff      = restart ? 16'd0 : cp_reg;
        hex_d       = hex_value(in_byte);
        esc_d       = escape_map(in_byte);
        cp_new      = {cp_eff[11:0], hex_d[3:0]};

        mode_next    = mode_eff;
        hex_cnt_next = hex_cnt_eff;
        cp_next      = cp_eff;
        burst        = '0;

        // Finishing result by default: no byte, last of run; status set per arm
        burst.res[0].last_of_run = 1'b1;

        unique case (mode_eff)
            MODE_NORMAL, MODE_ESCAPE, MODE_HEX:
            begin
                if (input_end) begin
                    burst.cnt = 2'd1;
                    mode_next = MODE_OUT;
                    hex_cnt_next = 2'd0;
                    cp_next = 16'd0;
                    if (mode_eff == MODE_ESCAPE) begin
                        burst.res[0].status = ST_UNFIN_ESC;
                    end
                    else if (mode_eff == MODE_HEX) begin
                        burst.res[0].status = ST_SHORT_U;
                    end
                    else begin
                        burst.res[0].status = ST_UNTERM;
                    end
                end
                else if (mode_eff == MODE_NORMAL) begin
                    priority if (in_byte == CHR_QUOTE) begin
                        burst.cnt = 2'd1;
                        burst.res[0].status = ST_DONE;
                        mode_next = MODE_OUT;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                    end
                    else if (in_byte < CHR_SPACE) begin
                        burst.cnt = 2'd1;
                        burst.res[0].status = ST_CTRL;
                        mode_next = MODE_OUT;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                    end
                    else if (in_byte == CHR_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                    else begin
                        burst.cnt = 2'd1;
                        burst.res[0].out_byte = in_byte;
                        burst.res[0].byte_valid = 1'b1;
                    end
                end
                else if (mode_eff == MODE_ESCAPE) begin
                    priority if (in_byte == CHR_U) begin
                        mode_next = MODE_HEX;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                    end
                    else if (esc_d[8]) begin
                        burst.cnt = 2'd1;
                        burst.res[0].out_byte = esc_d[7:0];
                        burst.res[0].byte_valid = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                    else begin
                        burst.cnt = 2'd1;
                        burst.res[0].status = ST_BAD_ESC;
                        mode_next = MODE_OUT;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                    end
                end
                else begin
                    priority if (!hex_d[4]) begin
                        burst.cnt = 2'd1;
                        burst.res[0].status = ST_BAD_HEX;
                        mode_next = MODE_OUT;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                    end
                    else if (hex_cnt_eff != 2'd3) begin
                        hex_cnt_next = hex_cnt_eff + 2'd1;
                        cp_next = cp_new;
                    end
                    else begin
                        // Fourth digit: encode the code point as UTF-8
                        mode_next = MODE_NORMAL;
                        hex_cnt_next = 2'd0;
                        cp_next = 16'd0;
                        burst.res[0].byte_valid = 1'b1;
                        burst.res[1].byte_valid = 1'b1;
                        burst.res[2].byte_valid = 1'b1;
                        priority if (cp_new <= 16'h007f) begin
                            burst.cnt = 2'd1;
                            burst.res[0].out_byte = cp_new[7:0];
                        end
                        else if (cp_new <= 16'h07ff) begin
                            burst.cnt = 2'd2;
                            burst.res[0].last_of_run = 1'b0;
                            burst.res[0].out_byte = 8'hc0 | {3'd0, cp_new[10:6]};
                            burst.res[1].out_byte = 8'h80 | {2'd0, cp_new[5:0]};
                            burst.res[1].last_of_run = 1'b1;
                        end
                        else begin
                            burst.cnt = 2'd3;
                            burst.res[0].last_of_run = 1'b0;
                            burst.res[0].out_byte = 8'he0 | {4'd0, cp_new[15:12]};
                            burst.res[1].out_byte = 8'h80 | {2'd0, cp_new[11:6]};
                            burst.res[2].out_byte = 8'h80 | {2'd0, cp_new[5:0]};
                            burst.res[2].last_of_run = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // Out of the string: every request reports it
                burst.cnt = 2'd1;
                burst.res[0].status = ST_NOT_IN;
                mode_next = MODE_OUT;
                hex_cnt_next = 2'd0;
                cp_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_NORMAL;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end
        else if (accept) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

`default_nettype wire

[rtl/json_string_unescape.sv]
// Each accepted request's results are written into the result queue, oldest at the output.
// Throughput: one request per cycle while s_axis_tready is high; each result leaves at
// one per cycle while m_axis_tready is high, so a \u escape that encodes to two or three
// UTF-8 bytes leaves as that many results. An 8-entry result queue sits between decoder
// and output; input stalls when more than five results are waiting. Reset (rst_n low,
// asynchronous) empties the queue and returns the decoder to the start of a string body.
`default_nettype none

module json_string_unescape
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic [1:0] s_axis_tuser,   // [0] input_end, [1] restart

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]      m_axis_tuser,   // [0] byte_valid, [4:1] status
    output logic            m_axis_tlast    // last_of_run
);

    // Room for a worst-case burst must remain before a request is taken
    localparam logic [CNT_W-1:0] ACCEPT_LIMIT = CNT_W'(RESULT_DEPTH - MAX_BURST);

    logic        accept;
    logic        pop;
    jsu_burst_t  burst;

    jsu_result_t            queue_reg [RESULT_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    jsu_result_t            head;

    assign s_axis_tready = (count_reg <= ACCEPT_LIMIT);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the request straight off the port against the held string state
    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .input_end (s_axis_tuser[0]),
        .restart   (s_axis_tuser[1]),
        .burst     (burst)
    );

    // Present the oldest queued result
    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = head.out_byte;
    assign m_axis_tuser  = {head.status, head.byte_valid};
    assign m_axis_tlast  = head.last_of_run;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(burst.cnt);
            count_next  = count_next + CNT_W'(burst.cnt);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    // Control: pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload: write the burst into consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BURST; i++) begin
            if (accept && (i < int'(burst.cnt))) begin
                queue_reg[wr_ptr_reg + PTR_W'(i)] <= burst.res[i];
            end
        end
    end

`ifndef SYNTHESIS
    // Fill count never exceeds the queue
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RESULT_DEPTH))
        else $error("result queue overfilled");

    // A UTF-8 lead byte always has its continuation bytes already queued
    a_burst_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (count_reg >= CNT_W'(2)))
        else $error("partial multi-byte burst in queue");

    // Status results carry no byte and end their run
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[4:1] != ST_BUSY))
            |-> (!m_axis_tuser[0] && m_axis_tlast))
        else $error("status result carries a byte");

    // Accepting a request that produces results leaves the queue non-empty
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (burst.cnt != 2'd0)) |=> m_axis_tvalid)
        else $error("accepted result not presented");
`endif

endmodule

`default_nettype wire
